/* sv/scaled_tanh_soft_limiter_top_assert.svh */
// Assertion macros used by the checker file of the soft limiter.
`ifndef SCALED_TANH_SOFT_LIMITER_TOP_ASSERT_SVH
`define SCALED_TANH_SOFT_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STSL_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("soft limiter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define STSL_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("soft limiter assertion failed");

`endif

/* sv/stsl_pkg.sv */
// Package of the soft limiter: payload types, pipeline constants and tanh table.
`default_nettype none
package stsl_pkg;

  localparam int TANH_TABLE_DEPTH = 256;
  localparam int IDX_BITS = $clog2(TANH_TABLE_DEPTH);
  localparam int FRAC_W = 16;
  // quotient of |x|*2^(16+IDX_BITS-3) / U, saturating at DEPTH*2^16
  localparam int QUO_BITS = IDX_BITS + FRAC_W;
  localparam int NUM_SHIFT = QUO_BITS - 3;
  localparam int ROM_W = 17;
  // input register, one stage per quotient bit, five arithmetic stages
  localparam int STSL_LATENCY = QUO_BITS + 6;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               last_in;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               last_out;
  } result_t;

  typedef logic [ROM_W-1:0] rom_t [0:TANH_TABLE_DEPTH];

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Q16 tanh(k*8/DEPTH), built from a fifth order exp series squared 8 times
  function automatic rom_t tanh_rom_build();
    rom_t        rom;
    logic [63:0] r;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    int          k;
    int          sq;
    int          b;
    for (k = 0; k <= TANH_TABLE_DEPTH; k++) begin
      r = ((64'(k) << 34) / TANH_TABLE_DEPTH) >> 8;
      sum = Q30_ONE;
      term = Q30_ONE;
      term = ((term * r) >> 30);
      sum = (sum >= term) ? sum - term : 64'd0;
      term = ((term * r) >> 30) / 2;
      sum = sum + term;
      term = ((term * r) >> 30) / 3;
      sum = (sum >= term) ? sum - term : 64'd0;
      term = ((term * r) >> 30) / 4;
      sum = sum + term;
      term = ((term * r) >> 30) / 5;
      sum = (sum >= term) ? sum - term : 64'd0;
      for (sq = 0; sq < 8; sq++) begin
        sum = (sum * sum) >> 30;
      end
      num = ((Q30_ONE - sum) << 16);
      den = Q30_ONE + sum;
      num = num + (den >> 1);
      rem = 64'd0;
      quo = 64'd0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem = rem - den;
          quo[b] = 1'b1;
        end
      end
      rom[k] = quo[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

/* sv/scaled_tanh_soft_limiter_top.sv */
// Top level of the soft limiter: y = U*tanh(x/U) through a deep pipeline.
//
//  channel   direction  handshake                 payload
//  item      in         start && !busy            item_t (sample_in, last_in)
//  result    out        done, one cycle, no stall result_t (sample_out, last_out)
//  cfg       in         cfg_valid && cfg_ready    cfg_data (upper_bound)
//
// One sample enters every cycle; its result passes the input register, the restoring
// divider, one quotient bit per stage (24), and the table read, interpolation multiply,
// add, scale and round stages.
// busy stays low and cfg_ready stays high; the receiver cannot stall results.
// Synchronous reset clears valid bits and restores upper_bound to 1536.
`default_nettype none
module scaled_tanh_soft_limiter_top
  import stsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [14:0] cfg_data
);

  localparam rom_t TANH_ROM = tanh_rom_build();

  logic [14:0] upper_bound;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // hold the bound, load on a config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound <= 15'd1536;
    end else if (cfg_valid && cfg_ready) begin
      upper_bound <= cfg_data;
    end
  end

  // divider stage registers
  logic                div_vld  [0:QUO_BITS];
  logic                div_neg  [0:QUO_BITS];
  logic                div_last [0:QUO_BITS];
  logic                div_sat  [0:QUO_BITS];
  logic [2:0]          div_low  [0:QUO_BITS];
  logic [15:0]         div_rem  [0:QUO_BITS];
  logic [QUO_BITS-1:0] div_quo  [0:QUO_BITS];

  logic        in_neg;
  logic [15:0] in_mag;

  assign in_neg = item.sample_in[15];
  assign in_mag = in_neg ? 16'(-item.sample_in) : item.sample_in;

  // capture the sample magnitude and the saturation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else begin
      div_vld[0] <= start && !busy;
    end
    div_neg[0]  <= in_neg;
    div_last[0] <= item.last_in;
    div_sat[0]  <= {1'b0, in_mag} >= {upper_bound, 3'b000};
    div_low[0]  <= in_mag[2:0];
    div_rem[0]  <= {3'b000, in_mag[15:3]};
    div_quo[0]  <= '0;
  end

  // advance one quotient bit per stage
  for (genvar s = 1; s <= QUO_BITS; s++) begin : g_div
    localparam int B = QUO_BITS - s;
    logic        nbit;
    logic [15:0] shifted;
    logic        ge;
    if (B >= NUM_SHIFT) begin : g_bit
      assign nbit = div_low[s-1][B-NUM_SHIFT];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign shifted = {div_rem[s-1][14:0], nbit};
    assign ge = shifted >= {1'b0, upper_bound};
    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[s] <= 1'b0;
      end else begin
        div_vld[s] <= div_vld[s-1];
      end
      div_neg[s]  <= div_neg[s-1];
      div_last[s] <= div_last[s-1];
      div_sat[s]  <= div_sat[s-1];
      div_low[s]  <= div_low[s-1];
      div_rem[s]  <= ge ? shifted - {1'b0, upper_bound} : shifted;
      div_quo[s]  <= div_quo[s-1] | (QUO_BITS'(ge) << B);
    end
  end

  // table read stage
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS:0]   idx_hi;
  logic [ROM_W-1:0]    rom_lo;
  logic [ROM_W-1:0]    rom_hi;

  assign idx    = div_quo[QUO_BITS][QUO_BITS-1:FRAC_W];
  assign idx_hi = {1'b0, idx} + 1'b1;
  assign rom_lo = TANH_ROM[{1'b0, idx}];
  assign rom_hi = TANH_ROM[idx_hi];

  logic              a_vld, a_neg, a_last, a_sat, a_dneg;
  logic [ROM_W-1:0]  a_lo, a_dmag;
  logic [FRAC_W-1:0] a_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= div_vld[QUO_BITS];
    end
    a_neg  <= div_neg[QUO_BITS];
    a_last <= div_last[QUO_BITS];
    a_sat  <= div_sat[QUO_BITS];
    a_lo   <= rom_lo;
    a_dneg <= rom_hi < rom_lo;
    a_dmag <= (rom_hi < rom_lo) ? rom_lo - rom_hi : rom_hi - rom_lo;
    a_frac <= div_quo[QUO_BITS][FRAC_W-1:0];
  end

  // interpolation multiply
  logic                    b_vld, b_neg, b_last, b_sat, b_dneg;
  logic [ROM_W-1:0]        b_lo;
  logic [ROM_W+FRAC_W-1:0] b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_neg  <= a_neg;
    b_last <= a_last;
    b_sat  <= a_sat;
    b_dneg <= a_dneg;
    b_lo   <= a_lo;
    b_prod <= a_dmag * a_frac;
  end

  // round the step and form t
  logic [ROM_W+FRAC_W:0] b_round;
  logic [ROM_W-1:0]      b_step;

  assign b_round = {1'b0, b_prod} + (ROM_W+FRAC_W+1)'(32768);
  assign b_step  = b_round[ROM_W+FRAC_W-1:FRAC_W];

  logic             c_vld, c_neg, c_last;
  logic [ROM_W-1:0] c_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_neg  <= b_neg;
    c_last <= b_last;
    if (b_sat) begin
      c_t <= ROM_W'(65536);
    end else if (b_dneg) begin
      c_t <= b_lo - b_step;
    end else begin
      c_t <= b_lo + b_step;
    end
  end

  // scale by the bound
  logic        d_vld, d_neg, d_last;
  logic [31:0] d_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_neg  <= c_neg;
    d_last <= c_last;
    d_prod <= upper_bound * c_t;
  end

  // round, clamp to the bound and restore the sign
  logic [32:0] d_round;
  logic [16:0] d_y;
  logic [15:0] d_mag;

  assign d_round = {1'b0, d_prod} + 33'd32768;
  assign d_y     = d_round[32:16];
  assign d_mag   = (d_y > {2'b00, upper_bound}) ? {1'b0, upper_bound} : d_y[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld;
    end
    result.sample_out <= d_neg ? 16'(-d_mag) : d_mag;
    result.last_out   <= d_last;
  end

endmodule
`default_nettype wire

/* sv/stsl_checker.sv */
// Port-level checker of the soft limiter and its bind to the top level.
`default_nettype none
`include "scaled_tanh_soft_limiter_top_assert.svh"
module stsl_checker
  import stsl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire item_t       item,
  input wire logic        done,
  input wire result_t     result,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  logic accept;
  logic in_last;
  logic in_sign;
  logic out_sign;
  logic out_nz;

  assign accept   = start && !busy;
  assign in_last  = item.last_in;
  assign in_sign  = item.sample_in[15];
  assign out_sign = result.sample_out[15];
  assign out_nz   = done && result.sample_out != 16'sd0;

  `STSL_ASSERT_IMPL(a_result_follows, clk, rst, accept, ##STSL_LATENCY done)
  `STSL_ASSERT_IMPL(a_no_spurious, clk, rst, done, $past(accept, STSL_LATENCY))
  `STSL_ASSERT_IMPL(a_last_kept, clk, rst, done, result.last_out == $past(in_last, STSL_LATENCY))
  `STSL_ASSERT_IMPL(a_sign_kept, clk, rst, out_nz, out_sign == $past(in_sign, STSL_LATENCY))
  `STSL_ASSERT_NEXT(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind scaled_tanh_soft_limiter_top stsl_checker u_stsl_checker (.*);
`default_nettype wire
